[hdl/eav_pkg.sv]
// ----------------------------------------------------------------------------
// eav_pkg
// Types and constants shared by the Euler-angle vector rotation blocks.
// ----------------------------------------------------------------------------
package eav_pkg;

    localparam int MaxIter = 30;

    // round(pi/180 * 2^32)
    localparam logic signed [27:0] Deg2Rad = 28'sd74961321;
    // CORDIC start value, inverse of the infinite-step gain in Q2.30
    localparam logic signed [33:0] GainQ30 = 34'sd652032874;
    localparam logic signed [32:0] OneQ30 = 33'sd1073741824;

    localparam logic [29:0] AtanQ30 [MaxIter] = '{
        30'd843314857, 30'd497837829, 30'd263043837, 30'd133525159, 30'd67021687,
        30'd33543516,  30'd16775851,  30'd8388437,   30'd4194283,   30'd2097149,
        30'd1048576,   30'd524288,    30'd262144,    30'd131072,    30'd65536,
        30'd32768,     30'd16384,     30'd8192,      30'd4096,      30'd2048,
        30'd1024,      30'd512,       30'd256,       30'd128,       30'd64,
        30'd32,        30'd16,        30'd8,         30'd4,         30'd2
    };

    typedef struct packed {
        logic signed [31:0] vec_x;
        logic signed [31:0] vec_y;
        logic signed [31:0] vec_z;
        logic signed [31:0] pitch_deg;
        logic signed [31:0] yaw_deg;
        logic signed [31:0] roll_deg;
    } t_in_item;

    typedef struct packed {
        logic signed [31:0] out_x;
        logic signed [31:0] out_y;
        logic signed [31:0] out_z;
        logic               saturated;
    } t_out_item;

    // one angle in flight: CORDIC x, y, residual z and cosine sign flip
    typedef struct packed {
        logic signed [33:0] x;
        logic signed [33:0] y;
        logic signed [33:0] z;
        logic               neg;
    } t_lane;

    // lane 0 pitch, lane 1 yaw, lane 2 roll
    typedef struct packed {
        t_lane [2:0]        lane;
        logic signed [31:0] vec_x;
        logic signed [31:0] vec_y;
        logic signed [31:0] vec_z;
    } t_cell;

endpackage

[hdl/eav_if.sv]
// ----------------------------------------------------------------------------
// eav_if
// Valid/ready channels for input items and result items.
// ----------------------------------------------------------------------------
interface eav_in_if import eav_pkg::*; ();
    logic     valid;
    logic     ready;
    t_in_item data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface eav_out_if import eav_pkg::*; ();
    logic      valid;
    logic      ready;
    t_out_item data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

[hdl/eav_prep.sv]
// ----------------------------------------------------------------------------
// eav_prep
// Four-stage angle front end: reduce mod 360, fold to +-90 degrees, convert
// to Q2.30 radians and load the CORDIC start values.
// ----------------------------------------------------------------------------
module eav_prep import eav_pkg::*; #(
    parameter int FRAC_BITS = 16
) (
    input  logic     i_clk,
    input  logic     i_en,
    input  t_in_item i_item,
    output t_cell    o_cell
);

    localparam int W   = 32 - FRAC_BITS;   // integer degrees
    localparam int UW  = W + 1;            // offset integer degrees
    localparam int QW  = UW - 8;           // quotient by 360
    localparam int S   = UW + 9;           // reciprocal shift
    localparam int RW  = FRAC_BITS + 10;   // folded angle
    localparam int HW  = RW - 16;          // high part of folded angle
    localparam int PHW = HW + 28;
    localparam int PW  = PHW + 17;
    localparam logic [63:0] KOff   = ((64'd1 << (W - 1)) + 64'd359) / 64'd360;
    localparam logic [63:0] Off    = KOff * 64'd360;
    localparam logic [63:0] MRecip = ((64'd1 << S) + 64'd359) / 64'd360;
    localparam logic signed [RW-1:0] Full    = RW'(64'd360 << FRAC_BITS);
    localparam logic signed [RW-1:0] Half    = RW'(64'd180 << FRAC_BITS);
    localparam logic signed [RW-1:0] Quarter = RW'(64'd90 << FRAC_BITS);

    logic signed [31:0] w_deg [3];
    logic [UW-1:0]      w_u   [3];
    logic [2*UW:0]      w_prod[3];
    logic [UW-1:0]      w_rem [3];
    logic signed [RW-1:0] w_t [3];
    logic               w_neg [3];
    logic signed [PW-1:0] w_p [3];
    logic signed [PW-1:0] w_zs[3];

    logic [UW-1:0]        r_u   [3];
    logic [QW-1:0]        r_q   [3];
    logic [FRAC_BITS-1:0] r_f   [3];
    logic signed [RW-1:0] r_r   [3];
    logic                 r_neg2[3];
    logic signed [PHW-1:0] r_phi[3];
    logic signed [44:0]   r_plo [3];
    logic                 r_neg3[3];
    logic signed [31:0]   r_vec [3][3];

    assign w_deg[0] = i_item.pitch_deg;
    assign w_deg[1] = i_item.yaw_deg;
    assign w_deg[2] = i_item.roll_deg;

    for (genvar g = 0; g < 3; g++) begin : g_lane
        // floor-mod: integer degrees mod 360, fraction bits kept as they are
        always_comb begin
            w_u[g]    = {w_deg[g][31], w_deg[g][31:FRAC_BITS]} + Off[UW-1:0];
            w_prod[g] = w_u[g] * MRecip[UW:0];
        end

        always_comb begin
            w_rem[g] = r_u[g] - UW'(r_q[g]) * UW'(360);
            w_t[g]   = {1'b0, w_rem[g][8:0], r_f[g]};
            w_neg[g] = 1'b0;
            if (w_t[g] > Half) begin
                w_t[g] = w_t[g] - Full;
            end
            if (w_t[g] > Quarter) begin
                w_t[g]   = Half - w_t[g];
                w_neg[g] = 1'b1;
            end else if (w_t[g] < -Quarter) begin
                w_t[g]   = -Half - w_t[g];
                w_neg[g] = 1'b1;
            end
        end

        always_comb begin
            w_p[g]  = (PW'(r_phi[g]) <<< 16) + PW'(r_plo[g]);
            w_zs[g] = w_p[g] >>> (FRAC_BITS + 2);
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_u[g]    <= w_u[g];
                r_q[g]    <= w_prod[g][2*UW -: QW];
                r_f[g]    <= w_deg[g][FRAC_BITS-1:0];
                r_r[g]    <= w_t[g];
                r_neg2[g] <= w_neg[g];
                r_phi[g]  <= HW'(r_r[g] >>> 16) * Deg2Rad;
                r_plo[g]  <= $signed({1'b0, r_r[g][15:0]}) * Deg2Rad;
                r_neg3[g] <= r_neg2[g];
            end
        end
    end

    // carry the vector alongside the angles and load the CORDIC start values
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_vec[0][0] <= i_item.vec_x;
            r_vec[0][1] <= i_item.vec_y;
            r_vec[0][2] <= i_item.vec_z;
            r_vec[1]    <= r_vec[0];
            r_vec[2]    <= r_vec[1];
            o_cell.vec_x <= r_vec[2][0];
            o_cell.vec_y <= r_vec[2][1];
            o_cell.vec_z <= r_vec[2][2];
            for (int k = 0; k < 3; k++) begin
                o_cell.lane[k].x   <= GainQ30;
                o_cell.lane[k].y   <= '0;
                o_cell.lane[k].z   <= w_zs[k][33:0];
                o_cell.lane[k].neg <= r_neg3[k];
            end
        end
    end

endmodule

[hdl/eav_cordic_cell.sv]
// ----------------------------------------------------------------------------
// eav_cordic_cell
// One rotation-mode CORDIC step for all three angles.
// ----------------------------------------------------------------------------
module eav_cordic_cell import eav_pkg::*; #(
    parameter int STEP = 0
) (
    input  logic  i_clk,
    input  logic  i_en,
    input  t_cell i_cell,
    output t_cell o_cell
);

    localparam logic signed [33:0] Atan = {4'b0, AtanQ30[STEP]};

    t_cell n_cell;

    always_comb begin
        n_cell = i_cell;
        for (int k = 0; k < 3; k++) begin
            if (!i_cell.lane[k].z[33]) begin
                n_cell.lane[k].x = i_cell.lane[k].x - (i_cell.lane[k].y >>> STEP);
                n_cell.lane[k].y = i_cell.lane[k].y + (i_cell.lane[k].x >>> STEP);
                n_cell.lane[k].z = i_cell.lane[k].z - Atan;
            end else begin
                n_cell.lane[k].x = i_cell.lane[k].x + (i_cell.lane[k].y >>> STEP);
                n_cell.lane[k].y = i_cell.lane[k].y - (i_cell.lane[k].x >>> STEP);
                n_cell.lane[k].z = i_cell.lane[k].z + Atan;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_cell <= n_cell;
        end
    end

endmodule

[hdl/eav_matrix.sv]
// ----------------------------------------------------------------------------
// eav_matrix
// Five-stage back end: build the rotation matrix from sines and cosines,
// dot each row with the vector, truncate and saturate.
// ----------------------------------------------------------------------------
module eav_matrix import eav_pkg::*; (
    input  logic      i_clk,
    input  logic      i_en,
    input  t_cell     i_cell,
    output t_out_item o_item
);

    function automatic logic signed [32:0] mq(input logic signed [32:0] a,
                                              input logic signed [32:0] b);
        logic signed [65:0] p;
        p = a * b;
        return p[62:30];
    endfunction

    function automatic logic signed [31:0] clamp_unit(input logic signed [33:0] v);
        logic signed [31:0] r;
        if (v > 34'(OneQ30)) begin
            r = 32'(OneQ30);
        end else if (v < -34'(OneQ30)) begin
            r = -32'(OneQ30);
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

    logic signed [33:0] w_cneg[3];
    logic signed [32:0] w_s[3];
    logic signed [32:0] w_c[3];

    // stage 1 products
    logic signed [32:0] r_cpcy, r_cpsy, r_srsp, r_crsy, r_crcy, r_srcp;
    logic signed [32:0] r_crsp, r_srsy, r_srcy, r_crcp, r_msp, r_cy, r_sy;
    // stage 2
    logic signed [32:0] r_t3, r_t4, r_t6, r_t7;
    logic signed [32:0] r2_cpcy, r2_cpsy, r2_msp, r2_srcp, r2_crcp;
    logic signed [32:0] r2_crsy, r2_crcy, r2_srsy, r2_srcy;
    // stage 3 matrix, stage 4 products
    logic signed [31:0] r_m[9];
    logic signed [63:0] r_pr[9];
    logic signed [31:0] r_vec[3][3];

    logic signed [65:0] w_sum[3];
    logic signed [35:0] w_sh[3];
    logic               w_sat[3];
    logic signed [31:0] w_out[3];

    for (genvar g = 0; g < 3; g++) begin : g_sc
        always_comb begin
            w_cneg[g] = i_cell.lane[g].neg ? -i_cell.lane[g].x : i_cell.lane[g].x;
            w_c[g]    = w_cneg[g][32:0];
            w_s[g]    = i_cell.lane[g].y[32:0];
        end
    end

    for (genvar g = 0; g < 3; g++) begin : g_row
        always_comb begin
            w_sum[g] = 66'(r_pr[3*g]) + 66'(r_pr[3*g+1]) + 66'(r_pr[3*g+2]);
            w_sh[g]  = w_sum[g][65:30];
            w_sat[g] = 1'b1;
            if (w_sh[g] > 36'sd2147483647) begin
                w_out[g] = 32'h7fffffff;
            end else if (w_sh[g] < -36'sd2147483648) begin
                w_out[g] = 32'h80000000;
            end else begin
                w_out[g] = w_sh[g][31:0];
                w_sat[g] = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            // lane 0 pitch, 1 yaw, 2 roll
            r_cpcy <= mq(w_c[0], w_c[1]);
            r_cpsy <= mq(w_c[0], w_s[1]);
            r_srsp <= mq(w_s[2], w_s[0]);
            r_crsy <= mq(w_c[2], w_s[1]);
            r_crcy <= mq(w_c[2], w_c[1]);
            r_srcp <= mq(w_s[2], w_c[0]);
            r_crsp <= mq(w_c[2], w_s[0]);
            r_srsy <= mq(w_s[2], w_s[1]);
            r_srcy <= mq(w_s[2], w_c[1]);
            r_crcp <= mq(w_c[2], w_c[0]);
            r_msp  <= -w_s[0];
            r_cy   <= w_c[1];
            r_sy   <= w_s[1];

            r_t3    <= mq(r_srsp, r_cy);
            r_t4    <= mq(r_srsp, r_sy);
            r_t6    <= mq(r_crsp, r_cy);
            r_t7    <= mq(r_crsp, r_sy);
            r2_cpcy <= r_cpcy;
            r2_cpsy <= r_cpsy;
            r2_msp  <= r_msp;
            r2_srcp <= r_srcp;
            r2_crcp <= r_crcp;
            r2_crsy <= r_crsy;
            r2_crcy <= r_crcy;
            r2_srsy <= r_srsy;
            r2_srcy <= r_srcy;

            r_m[0] <= clamp_unit(34'(r2_cpcy));
            r_m[1] <= clamp_unit(34'(r2_cpsy));
            r_m[2] <= clamp_unit(34'(r2_msp));
            r_m[3] <= clamp_unit(34'(r_t3) - 34'(r2_crsy));
            r_m[4] <= clamp_unit(34'(r_t4) + 34'(r2_crcy));
            r_m[5] <= clamp_unit(34'(r2_srcp));
            r_m[6] <= clamp_unit(34'(r_t6) + 34'(r2_srsy));
            r_m[7] <= clamp_unit(34'(r_t7) - 34'(r2_srcy));
            r_m[8] <= clamp_unit(34'(r2_crcp));

            r_vec[0][0] <= i_cell.vec_x;
            r_vec[0][1] <= i_cell.vec_y;
            r_vec[0][2] <= i_cell.vec_z;
            r_vec[1]    <= r_vec[0];
            r_vec[2]    <= r_vec[1];

            for (int k = 0; k < 9; k++) begin
                r_pr[k] <= r_vec[2][k % 3] * r_m[k];
            end

            o_item.out_x     <= w_out[0];
            o_item.out_y     <= w_out[1];
            o_item.out_z     <= w_out[2];
            o_item.saturated <= w_sat[0] | w_sat[1] | w_sat[2];
        end
    end

endmodule

[hdl/euler_angle_vector_rotate.sv]
// ----------------------------------------------------------------------------
// euler_angle_vector_rotate
// Rotates a Q16.16 vector by pitch, yaw and roll given in degrees.
// ----------------------------------------------------------------------------
// Fully pipelined: one beat is taken every cycle while the output side keeps
// up. Each result passes through 4 angle-reduction stages, one CORDIC cell
// per iteration and 5 matrix and dot-product stages, the last of which is the
// output register. The whole chain holds while a result waits on a low
// o_out.ready.
module euler_angle_vector_rotate import eav_pkg::*; #(
    parameter int CORDIC_STEPS = 16,
    parameter int FRAC_BITS    = 16
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    eav_in_if.sink        i_in,
    eav_out_if.source     o_out
);

    localparam int N = (CORDIC_STEPS > MaxIter) ? MaxIter : CORDIC_STEPS;
    localparam int L = N + 9;

    logic         w_adv;
    logic [L-1:0] r_valid;
    logic [L-1:0] n_valid;
    t_cell        w_cell[N+1];

    assign w_adv      = !r_valid[L-1] || o_out.ready;
    assign i_in.ready = w_adv;
    assign o_out.valid = r_valid[L-1];

    always_comb begin
        n_valid = r_valid;
        if (w_adv) begin
            n_valid = {r_valid[L-2:0], i_in.valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else begin
            r_valid <= n_valid;
        end
    end

    eav_prep #(.FRAC_BITS(FRAC_BITS)) u_prep (
        .i_clk  (i_clk),
        .i_en   (w_adv),
        .i_item (i_in.data),
        .o_cell (w_cell[0])
    );

    for (genvar g = 0; g < N; g++) begin : g_cell
        eav_cordic_cell #(.STEP(g)) u_cell (
            .i_clk  (i_clk),
            .i_en   (w_adv),
            .i_cell (w_cell[g]),
            .o_cell (w_cell[g+1])
        );
    end

    eav_matrix u_matrix (
        .i_clk  (i_clk),
        .i_en   (w_adv),
        .i_cell (w_cell[N]),
        .o_item (o_out.data)
    );

    a_reset_empty: assert property (@(posedge i_clk) !i_rst_n |=> !o_out.valid)
        else $error("result valid right after reset");

    a_accept_enters: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in.valid && i_in.ready) |=> r_valid[0])
        else $error("accepted beat missing from first stage");

    a_sat_clipped: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.data.saturated) |->
        (o_out.data.out_x == 32'sh7fffffff || o_out.data.out_x == 32'sh80000000 ||
         o_out.data.out_y == 32'sh7fffffff || o_out.data.out_y == 32'sh80000000 ||
         o_out.data.out_z == 32'sh7fffffff || o_out.data.out_z == 32'sh80000000))
        else $error("saturation flag without a clipped component");

endmodule

[tb/sv/euler_angle_vector_rotate_tb.sv]
// ----------------------------------------------------------------------------
// euler_angle_vector_rotate_tb
// Drives random and directed vectors and angles into the rotation pipeline,
// predicts each result with a fixed-point model of its own and checks every
// output beat in order, with random idle bursts on both channels.
// ----------------------------------------------------------------------------
module euler_angle_vector_rotate_tb;
    import eav_pkg::*;

    localparam int Steps   = 16;
    localparam int Frac    = 16;
    localparam int Latency = 9 + ((Steps > MaxIter) ? MaxIter : Steps);
    localparam int NumRand = 1050;
    localparam int Quiet   = 2000;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    bit   failed = 1'b0;
    int   idle_cycles = 0;

    eav_in_if  in_ch ();
    eav_out_if out_ch ();

    euler_angle_vector_rotate #(.CORDIC_STEPS(Steps), .FRAC_BITS(Frac)) dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_in   (in_ch.sink),
        .o_out  (out_ch.source)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // floor shift for signed 64-bit values
    function automatic longint floor_shr(longint v, int s);
        return v >>> s;
    endfunction

    function automatic longint unit_clamp(longint v);
        if (v > OneQ30) return OneQ30;
        if (v < -OneQ30) return -OneQ30;
        return v;
    endfunction

    function automatic longint qmul(longint a, longint b);
        return floor_shr(a * b, 30);
    endfunction

    function automatic void angle_sin_cos(input logic signed [31:0] deg, output longint s,
                                          output longint c);
        longint full, half, quarter, r, x, y, z, nx;
        bit     flip;
        int     n;
        full = 360 <<< Frac;
        half = 180 <<< Frac;
        quarter = 90 <<< Frac;
        flip = 1'b0;
        r = longint'(deg) % full;
        if (r < 0) r += full;
        if (r > half) r -= full;
        if (r > quarter) begin
            r = half - r;
            flip = 1'b1;
        end else if (r < -quarter) begin
            r = -half - r;
            flip = 1'b1;
        end
        z = floor_shr(r * longint'(Deg2Rad), Frac + 2);
        x = GainQ30;
        y = 0;
        n = (Steps > MaxIter) ? MaxIter : Steps;
        for (int i = 0; i < n; i++) begin
            if (z >= 0) begin
                nx = x - floor_shr(y, i);
                y = y + floor_shr(x, i);
                z -= longint'(AtanQ30[i]);
            end else begin
                nx = x + floor_shr(y, i);
                y = y - floor_shr(x, i);
                z += longint'(AtanQ30[i]);
            end
            x = nx;
        end
        s = y;
        c = flip ? -x : x;
    endfunction

    function automatic logic signed [31:0] row_dot(t_in_item it, longint m0, longint m1,
                                                   longint m2, ref bit sat);
        longint sum;
        sum = floor_shr(longint'(it.vec_x) * m0 + longint'(it.vec_y) * m1
                        + longint'(it.vec_z) * m2, 30);
        if (sum > 64'sd2147483647) begin
            sat = 1'b1;
            return 32'sh7fffffff;
        end
        if (sum < -64'sd2147483648) begin
            sat = 1'b1;
            return 32'sh80000000;
        end
        return sum[31:0];
    endfunction

    function automatic t_out_item rotate_predict(t_in_item it);
        longint    sp, cp, sy, cy, sr, cr;
        longint    m [9];
        bit        sat;
        t_out_item r;
        sat = 1'b0;
        angle_sin_cos(it.pitch_deg, sp, cp);
        angle_sin_cos(it.yaw_deg, sy, cy);
        angle_sin_cos(it.roll_deg, sr, cr);
        m[0] = qmul(cp, cy);
        m[1] = qmul(cp, sy);
        m[2] = -sp;
        m[3] = qmul(qmul(sr, sp), cy) - qmul(cr, sy);
        m[4] = qmul(qmul(sr, sp), sy) + qmul(cr, cy);
        m[5] = qmul(sr, cp);
        m[6] = qmul(qmul(cr, sp), cy) + qmul(sr, sy);
        m[7] = qmul(qmul(cr, sp), sy) - qmul(sr, cy);
        m[8] = qmul(cr, cp);
        foreach (m[k]) m[k] = unit_clamp(m[k]);
        r.out_x = row_dot(it, m[0], m[1], m[2], sat);
        r.out_y = row_dot(it, m[3], m[4], m[5], sat);
        r.out_z = row_dot(it, m[6], m[7], m[8], sat);
        r.saturated = sat;
        return r;
    endfunction

    class rotation_scoreboard;
        t_out_item pending[$];

        function void note_input(t_in_item it);
            pending.push_back(rotate_predict(it));
        endfunction

        function void check_result(t_out_item got);
            t_out_item exp_r;
            if (pending.size() == 0) begin
                $error("result beat with no pending prediction: %h", got);
                failed = 1'b1;
                return;
            end
            exp_r = pending.pop_front();
            if (got.out_x !== exp_r.out_x) begin
                $error("out_x expected %0d actual %0d", exp_r.out_x, got.out_x);
                failed = 1'b1;
            end
            if (got.out_y !== exp_r.out_y) begin
                $error("out_y expected %0d actual %0d", exp_r.out_y, got.out_y);
                failed = 1'b1;
            end
            if (got.out_z !== exp_r.out_z) begin
                $error("out_z expected %0d actual %0d", exp_r.out_z, got.out_z);
                failed = 1'b1;
            end
            if (got.saturated !== exp_r.saturated) begin
                $error("saturated expected %0b actual %0b", exp_r.saturated, got.saturated);
                failed = 1'b1;
            end
        endfunction
    endclass

    rotation_scoreboard board = new();
    bit calm = 1'b0;

    initial begin
        in_ch.valid = 1'b0;
        in_ch.data = '0;
        out_ch.ready = 1'b0;
    end

    // sample both channels at the rising edge
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (in_ch.valid && in_ch.ready) board.note_input(in_ch.data);
            if (out_ch.valid && out_ch.ready) board.check_result(out_ch.data);
            if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= Quiet) begin
                $display("euler_angle_vector_rotate_tb: FAIL");
                $finish;
            end
        end
    end

    // receiver: random stall bursts, none near the end
    initial begin
        int n;
        @(posedge i_rst_n);
        forever begin
            @(negedge i_clk);
            if (!calm && $urandom_range(0, 7) == 0) begin
                n = $urandom_range(1, 7);
                out_ch.ready <= 1'b0;
                repeat (n) @(negedge i_clk);
            end
            out_ch.ready <= 1'b1;
        end
    end

    function automatic logic signed [31:0] rand_angle();
        case ($urandom_range(0, 5))
            0: return $urandom;
            1: return ($urandom_range(0, 8) * 90) <<< Frac;
            2: return -($urandom_range(0, 2000) <<< Frac) + $urandom_range(0, 65535);
            default: return ($urandom_range(0, 720) - 360) * 65536 + $urandom_range(0, 65535);
        endcase
    endfunction

    function automatic logic signed [31:0] rand_comp();
        case ($urandom_range(0, 3))
            0: return $urandom;
            1: return $urandom_range(0, 1) ? 32'sh7fffffff : 32'sh80000000;
            default: return $signed($urandom_range(0, 32'h01ffffff)) - 32'sh01000000;
        endcase
    endfunction

    // present one beat at a falling edge and hold it until accepted
    task automatic send_beat(t_in_item it, bit gaps);
        if (gaps && $urandom_range(0, 5) == 0) begin
            in_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 7)) @(negedge i_clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.data <= it;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic send_directed();
        t_in_item it;
        logic signed [31:0] ang [8];
        ang = '{32'sd0, 360 <<< Frac, -(720 <<< Frac), 90 <<< Frac,
                -(90 <<< Frac), 180 <<< Frac, 32'sh7fffffff, 32'sh80000000};
        for (int i = 0; i < 8; i++) begin
            it.vec_x = 32'sh7fffffff;
            it.vec_y = 32'sh80000000;
            it.vec_z = (i % 2) ? 32'sh80000000 : 32'sh7fffffff;
            it.pitch_deg = ang[i];
            it.yaw_deg = ang[(i + 3) % 8];
            it.roll_deg = ang[(i + 5) % 8];
            send_beat(it, 1'b0);
        end
        for (int i = 0; i < 8; i++) begin
            it.vec_x = 32'sh00010000;
            it.vec_y = -32'sh00020000;
            it.vec_z = 32'sh00030000;
            it.pitch_deg = ang[i];
            it.yaw_deg = ang[i];
            it.roll_deg = ang[i];
            send_beat(it, 1'b0);
        end
    endtask

    initial begin
        t_in_item it;
        int wait_cnt;
        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);
        send_directed();
        for (int i = 0; i < NumRand; i++) begin
            if (i == NumRand / 2) begin
                // hold the sender until the pipeline drains
                in_ch.valid <= 1'b0;
                while (board.pending.size() != 0) @(negedge i_clk);
            end
            if (i == NumRand - 150) calm = 1'b1;
            it.vec_x = rand_comp();
            it.vec_y = rand_comp();
            it.vec_z = rand_comp();
            it.pitch_deg = rand_angle();
            it.yaw_deg = rand_angle();
            it.roll_deg = rand_angle();
            send_beat(it, !calm);
        end
        in_ch.valid <= 1'b0;
        wait_cnt = 0;
        while (board.pending.size() != 0 && wait_cnt < 100000) begin
            @(negedge i_clk);
            wait_cnt++;
        end
        repeat (Latency + 10) @(negedge i_clk);
        if (!failed && board.pending.size() == 0) begin
            $display("euler_angle_vector_rotate_tb: PASS");
        end else begin
            if (board.pending.size() != 0)
                $error("%0d predicted results never arrived", board.pending.size());
            $display("euler_angle_vector_rotate_tb: FAIL");
        end
        $finish;
    end
endmodule
